>>> sv/roi_gaussian_blur_rgb_assert.svh
// Assertion macros used by the port-level checker of this block.
// Each use expands to one concurrent assertion on clk, off during reset.
`ifndef ROI_GAUSSIAN_BLUR_RGB_ASSERT_SVH
`define ROI_GAUSSIAN_BLUR_RGB_ASSERT_SVH

// Same-cycle implication.
`define RGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rgb_blur_pkg.sv
// ----------------------------------------------------------------------------
// rgb_blur_pkg
// Types and constants of the region-limited RGB Gaussian blur.
// ----------------------------------------------------------------------------
package rgb_blur_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int STORE_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ACC_W       = 20;
    localparam int WSUM_W      = 12;

    // Q1.8 weights exp(-d2/2), rounded half up
    localparam logic [8:0] WT_CENTER = 9'd256;
    localparam logic [8:0] WT_EDGE   = 9'd155;
    localparam logic [8:0] WT_CORNER = 9'd94;

    localparam logic [2:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] CFG_ROI_START_X = 3'd1;
    localparam logic [2:0] CFG_ROI_START_Y = 3'd2;
    localparam logic [2:0] CFG_ROI_END_X   = 3'd3;
    localparam logic [2:0] CFG_ROI_END_Y   = 3'd4;

    typedef struct packed {
        logic       func;
        logic       start_of_frame;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       was_smoothed;
    } out_item_t;

endpackage

>>> sv/roi_gaussian_blur_rgb.sv
// ----------------------------------------------------------------------------
// roi_gaussian_blur_rgb
// 3x3 Gaussian blur of an RGB stream, limited to a configured rectangle.
// ----------------------------------------------------------------------------
// Flow: an item is taken and written to the line store, and its delayed pixel
//   read; a pass-through pixel then leaves, a smoothed one first reads nine
//   taps one a cycle on the single read port, then runs a restoring divide,
//   one quotient bit a cycle, before it leaves.
// Throughput: one item at a time; the input stalls until it is through.
// Reset: async, active low; counters and registers to defaults; the line
//   store is not cleared, the fill count keeps unwritten entries from view.
module roi_gaussian_blur_rgb (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rgb_blur_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rgb_blur_pkg::out_item_t out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [11:0]             cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CENTER = 5'b00010,
        S_READ   = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    localparam int AW   = rgb_blur_pkg::ADDR_W;
    localparam int ACCW = rgb_blur_pkg::ACC_W;
    localparam int WSW  = rgb_blur_pkg::WSUM_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(rgb_blur_pkg::STORE_DEPTH - 1);
    localparam logic [12:0]   DEPTH13   = 13'(rgb_blur_pkg::STORE_DEPTH);

    state_t state_reg;

    // configuration registers
    logic [10:0] image_width_reg;
    logic [10:0] roi_start_x_reg;
    logic [11:0] roi_start_y_reg;
    logic [10:0] roi_end_x_reg;
    logic [11:0] roi_end_y_reg;

    // line store: {pixel flag, r, g, b}
    logic [24:0]   mem [0:rgb_blur_pkg::STORE_DEPTH-1];
    logic [24:0]   rd_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // stream position
    logic [AW-1:0] wr_reg;
    logic [11:0]   fill_reg;
    logic [10:0]   col_reg;
    logic [11:0]   row_reg;

    // per-item context
    logic [AW-1:0] cur_wr_reg;
    logic [11:0]   cur_fill_reg;
    logic [10:0]   x_reg;
    logic [11:0]   y_reg;
    logic          chk_reg;

    // tap sequencing
    logic [1:0] ii_reg, jj_reg;
    logic       issue_done_reg;
    logic       pend_reg;
    logic       tap_ok_reg;
    logic [8:0] tap_wt_reg;

    logic [rgb_blur_pkg::ACC_W-1:0]  acc_r_reg, acc_g_reg, acc_b_reg;
    logic [rgb_blur_pkg::WSUM_W-1:0] wsum_reg;

    // divider
    logic [rgb_blur_pkg::ACC_W-1:0] dsh_reg;
    logic [2:0]                     bit_reg;
    logic [7:0]                     q_r_reg, q_g_reg, q_b_reg;

    rgb_blur_pkg::out_item_t res_reg;
    rgb_blur_pkg::out_item_t out_item_reg;
    logic                    out_valid_reg;

    // ---------------- effective width and delay ----------------
    logic [10:0] w_eff;
    logic [11:0] delay;
    always_comb
    begin
        if (image_width_reg == 11'd0)
            w_eff = 11'd1;
        else if (image_width_reg > 11'(rgb_blur_pkg::MAX_WIDTH))
            w_eff = 11'(rgb_blur_pkg::MAX_WIDTH);
        else
            w_eff = image_width_reg;
        delay = {1'b0, w_eff} + 12'd1;
    end

    // ---------------- accept-cycle bookkeeping ----------------
    logic          accept;
    logic          pix, restart;
    logic [AW-1:0] wr_eff;
    logic [11:0]   fill_eff, fill_new;
    logic [10:0]   col_eff;
    logic [11:0]   row_eff;
    logic          chk;
    logic [12:0]   c_sum;
    logic [AW-1:0] c_addr;
    logic [11:0]   col_inc;

    assign accept  = in_valid && !in_stall;
    assign pix     = !in_item.func;
    assign restart = pix && in_item.start_of_frame;

    always_comb
    begin
        wr_eff   = restart ? '0 : wr_reg;
        fill_eff = restart ? '0 : fill_reg;
        col_eff  = restart ? '0 : col_reg;
        row_eff  = restart ? '0 : row_reg;
        fill_new = (fill_eff < 12'(rgb_blur_pkg::STORE_DEPTH)) ? fill_eff + 12'd1 : fill_eff;
        chk      = fill_new > delay;
        c_sum    = 13'(wr_eff) + DEPTH13 - 13'(delay);
        c_addr   = (c_sum >= DEPTH13) ? AW'(c_sum - DEPTH13) : AW'(c_sum);
        col_inc  = 12'(col_eff) + 12'd1;
    end

    // ---------------- tap address and clipping ----------------
    logic [11:0]   nxp;
    logic [12:0]   nyp;
    logic [11:0]   jjw, back;
    logic [12:0]   idx_sum;
    logic [AW-1:0] idx;
    logic          ok_tap;
    logic [8:0]    wt;
    logic          in_roi;

    always_comb
    begin
        nxp = 12'(x_reg) + 12'(ii_reg);
        nyp = 13'(y_reg) + 13'(jj_reg);
        case (jj_reg)
            2'd0:    jjw = 12'd0;
            2'd1:    jjw = 12'(w_eff);
            default: jjw = {w_eff, 1'b0};
        endcase
        // distance back from the write pointer: 2w+2 - jj*w - ii
        back    = {w_eff, 1'b0} + 12'd2 - jjw - 12'(ii_reg);
        idx_sum = 13'(cur_wr_reg) + DEPTH13 - 13'(back);
        idx     = (idx_sum >= DEPTH13) ? AW'(idx_sum - DEPTH13) : AW'(idx_sum);
        ok_tap  = (nxp >= 12'(roi_start_x_reg) + 12'd1)
               && (nxp <  12'(roi_end_x_reg) + 12'd1)
               && (nxp <  12'(w_eff) + 12'd1)
               && (nyp >= 13'(roi_start_y_reg) + 13'd1)
               && (nyp <  13'(roi_end_y_reg) + 13'd1)
               && (back < cur_fill_reg);
        case ({(ii_reg != 2'd1), (jj_reg != 2'd1)})
            2'b00:   wt = rgb_blur_pkg::WT_CENTER;
            2'b11:   wt = rgb_blur_pkg::WT_CORNER;
            default: wt = rgb_blur_pkg::WT_EDGE;
        endcase
        in_roi = (x_reg >= roi_start_x_reg) && (x_reg < roi_end_x_reg) && (x_reg < w_eff)
              && (y_reg >= roi_start_y_reg) && (y_reg < roi_end_y_reg);
    end

    // ---------------- divider step ----------------
    logic [rgb_blur_pkg::ACC_W-1:0] r_sub, g_sub, b_sub;
    logic                           r_ge, g_ge, b_ge;
    logic [7:0]                     q_r_next, q_g_next, q_b_next;
    always_comb
    begin
        r_ge     = acc_r_reg >= dsh_reg;
        g_ge     = acc_g_reg >= dsh_reg;
        b_ge     = acc_b_reg >= dsh_reg;
        r_sub    = r_ge ? acc_r_reg - dsh_reg : acc_r_reg;
        g_sub    = g_ge ? acc_g_reg - dsh_reg : acc_g_reg;
        b_sub    = b_ge ? acc_b_reg - dsh_reg : acc_b_reg;
        q_r_next = {q_r_reg[6:0], r_ge};
        q_g_next = {q_g_reg[6:0], g_ge};
        q_b_next = {q_b_reg[6:0], b_ge};
    end

    // ---------------- line store ----------------
    assign mem_we  = accept;
    assign rd_addr = (state_reg == S_READ) ? idx : c_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_eff] <= {pix, in_item.in_red, in_item.in_green, in_item.in_blue};
        rd_reg <= mem[rd_addr];
    end

    // ---------------- control and datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            image_width_reg <= 11'd1024;
            roi_start_x_reg <= '0;
            roi_start_y_reg <= '0;
            roi_end_x_reg   <= '0;
            roi_end_y_reg   <= '0;
            wr_reg          <= '0;
            fill_reg        <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            cur_wr_reg      <= '0;
            cur_fill_reg    <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            chk_reg         <= 1'b0;
            ii_reg          <= '0;
            jj_reg          <= '0;
            issue_done_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            tap_ok_reg      <= 1'b0;
            tap_wt_reg      <= '0;
            acc_r_reg       <= '0;
            acc_g_reg       <= '0;
            acc_b_reg       <= '0;
            wsum_reg        <= '0;
            dsh_reg         <= '0;
            bit_reg         <= '0;
            q_r_reg         <= '0;
            q_g_reg         <= '0;
            q_b_reg         <= '0;
            res_reg         <= '0;
            out_item_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rgb_blur_pkg::CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[10:0];
                    rgb_blur_pkg::CFG_ROI_START_X: roi_start_x_reg <= cfg_data[10:0];
                    rgb_blur_pkg::CFG_ROI_START_Y: roi_start_y_reg <= cfg_data;
                    rgb_blur_pkg::CFG_ROI_END_X:   roi_end_x_reg   <= cfg_data[10:0];
                    rgb_blur_pkg::CFG_ROI_END_Y:   roi_end_y_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // S_OUT reloads the output register itself
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_wr_reg   <= wr_eff;
                        cur_fill_reg <= fill_new;
                        x_reg        <= col_eff;
                        y_reg        <= row_eff;
                        chk_reg      <= chk;
                        fill_reg     <= fill_new;
                        wr_reg       <= (wr_eff == LAST_ADDR) ? '0 : wr_eff + AW'(1);
                        if (chk)
                        begin
                            if (col_inc >= 12'(w_eff))
                            begin
                                col_reg <= '0;
                                row_reg <= row_eff + 12'd1;
                            end
                            else
                            begin
                                col_reg <= col_inc[10:0];
                                row_reg <= row_eff;
                            end
                        end
                        else
                        begin
                            col_reg <= col_eff;
                            row_reg <= row_eff;
                        end
                        state_reg <= S_CENTER;
                    end
                end

                S_CENTER:
                begin
                    // delayed pixel is in rd_reg
                    if (chk_reg && rd_reg[24])
                    begin
                        if (in_roi)
                        begin
                            acc_r_reg      <= '0;
                            acc_g_reg      <= '0;
                            acc_b_reg      <= '0;
                            wsum_reg       <= '0;
                            ii_reg         <= '0;
                            jj_reg         <= '0;
                            issue_done_reg <= 1'b0;
                            pend_reg       <= 1'b0;
                            state_reg      <= S_READ;
                        end
                        else
                        begin
                            res_reg   <= {rd_reg[23:16], rd_reg[15:8], rd_reg[7:0], 1'b0};
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        state_reg <= S_IDLE;
                end

                S_READ:
                begin
                    // accumulate the tap issued last cycle
                    if (pend_reg && tap_ok_reg && rd_reg[24])
                    begin
                        acc_r_reg <= acc_r_reg + ACCW'(rd_reg[23:16]) * ACCW'(tap_wt_reg);
                        acc_g_reg <= acc_g_reg + ACCW'(rd_reg[15:8]) * ACCW'(tap_wt_reg);
                        acc_b_reg <= acc_b_reg + ACCW'(rd_reg[7:0]) * ACCW'(tap_wt_reg);
                        wsum_reg  <= wsum_reg + WSW'(tap_wt_reg);
                    end
                    if (!issue_done_reg)
                    begin
                        tap_ok_reg <= ok_tap;
                        tap_wt_reg <= wt;
                        pend_reg   <= 1'b1;
                        if (ii_reg == 2'd2)
                        begin
                            ii_reg <= '0;
                            if (jj_reg == 2'd2)
                                issue_done_reg <= 1'b1;
                            else
                                jj_reg <= jj_reg + 2'd1;
                        end
                        else
                            ii_reg <= ii_reg + 2'd1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            dsh_reg   <= ACCW'({(wsum_reg == '0) ? WSW'(1) : wsum_reg, 7'd0});
                            bit_reg   <= 3'd7;
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    acc_r_reg <= r_sub;
                    acc_g_reg <= g_sub;
                    acc_b_reg <= b_sub;
                    q_r_reg   <= q_r_next;
                    q_g_reg   <= q_g_next;
                    q_b_reg   <= q_b_next;
                    dsh_reg   <= dsh_reg >> 1;
                    bit_reg   <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        res_reg   <= {q_r_next, q_g_next, q_b_next, 1'b1};
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_item_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> sv/rgb_blur_chk.sv
// ----------------------------------------------------------------------------
// rgb_blur_chk
// Port-level checker of the RGB blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "roi_gaussian_blur_rgb_assert.svh"

module rgb_blur_chk (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input rgb_blur_pkg::in_item_t  in_item,
    input logic                    out_valid,
    input logic                    out_stall,
    input rgb_blur_pkg::out_item_t out_item,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [2:0]              cfg_index,
    input logic [11:0]             cfg_data
);

    // one item at a time: a transaction closes the input side
    `RGB_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input open after transaction")

    // a new result only appears while the input side was closed
    `RGB_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(in_stall), "result without item")

    // a stalled result holds
    `RGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind roi_gaussian_blur_rgb rgb_blur_chk u_rgb_blur_chk (.*);

>>> tb/roi_gaussian_blur_rgb_checker.sv
// ----------------------------------------------------------------------------
// roi_gaussian_blur_rgb_checker
// Watches the pixel, result and register channels of the blur. It keeps its
// own line store, window arithmetic and register copy, predicts each result
// and compares it field by field.
// ----------------------------------------------------------------------------
module roi_gaussian_blur_rgb_checker
    import rgb_blur_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_SLOTS = 2 * MAX_WIDTH + 3;
    localparam int W_MID  = 256;
    localparam int W_SIDE = 155;
    localparam int W_DIAG = 94;

    logic [10:0] width_reg, x0_reg, x1_reg;
    logic [11:0] y0_reg, y1_reg;

    logic [23:0] line_pix [LINE_SLOTS];
    bit          line_ok  [LINE_SLOTS];
    int unsigned col_pos, row_pos, seen, wr_slot;

    out_item_t blurred_q[$];

    function automatic int tap_weight(int d2);
        if (d2 == 0)
            return W_MID;
        if (d2 == 1)
            return W_SIDE;
        return W_DIAG;
    endfunction

    // one accepted pixel transaction into the blur model
    task automatic absorb_pixel(in_item_t it);
        int w, dly, cslot, x, y, nx, ny, back, idx, wt, wsum;
        int acc [3];
        logic [23:0] px, v;
        out_item_t r;
        w = width_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        dly = w + 1;
        if (!it.func && it.start_of_frame)
        begin
            seen = 0;
            col_pos = 0;
            row_pos = 0;
            wr_slot = 0;
        end
        line_pix[wr_slot] = {it.in_red, it.in_green, it.in_blue};
        line_ok[wr_slot] = !it.func;
        if (seen < LINE_SLOTS)
            seen++;
        if (seen > dly)
        begin
            cslot = (wr_slot + LINE_SLOTS - dly) % LINE_SLOTS;
            x = col_pos;
            y = row_pos;
            if (line_ok[cslot])
            begin
                px = line_pix[cslot];
                if (x >= x0_reg && x < x1_reg && x < w && y >= y0_reg && y < y1_reg)
                begin
                    acc = '{0, 0, 0};
                    wsum = 0;
                    for (int j = -1; j <= 1; j++)
                    begin
                        for (int i = -1; i <= 1; i++)
                        begin
                            nx = x + i;
                            ny = y + j;
                            if (nx < x0_reg || nx >= x1_reg || nx >= w)
                                continue;
                            if (ny < y0_reg || ny >= y1_reg)
                                continue;
                            back = dly - j * w - i;
                            if (back < 0 || back >= seen)
                                continue;
                            idx = (wr_slot + LINE_SLOTS - back) % LINE_SLOTS;
                            if (!line_ok[idx])
                                continue;
                            wt = tap_weight(i * i + j * j);
                            v = line_pix[idx];
                            acc[0] += v[23:16] * wt;
                            acc[1] += v[15:8] * wt;
                            acc[2] += v[7:0] * wt;
                            wsum += wt;
                        end
                    end
                    if (wsum == 0)
                        wsum = 1;
                    r.out_red      = 8'(acc[0] / wsum);
                    r.out_green    = 8'(acc[1] / wsum);
                    r.out_blue     = 8'(acc[2] / wsum);
                    r.was_smoothed = 1'b1;
                end
                else
                begin
                    r = {px, 1'b0};
                end
                blurred_q.push_back(r);
            end
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = (row_pos + 1) & 12'hFFF;
            end
        end
        wr_slot = (wr_slot + 1) % LINE_SLOTS;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            width_reg = 11'd1024;
            x0_reg = '0;
            x1_reg = '0;
            y0_reg = '0;
            y1_reg = '0;
            col_pos = 0;
            row_pos = 0;
            seen = 0;
            wr_slot = 0;
            errors = 0;
            foreach (line_ok[k])
                line_ok[k] = 0;
            blurred_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, out_item);
                    errors++;
                end
                else
                begin
                    e = blurred_q.pop_front();
                    if (out_item.out_red !== e.out_red || out_item.out_green !== e.out_green ||
                        out_item.out_blue !== e.out_blue ||
                        out_item.was_smoothed !== e.was_smoothed)
                    begin
                        $display("%0t: result mismatch expected r%0d g%0d b%0d s%0d, got r%0d g%0d b%0d s%0d",
                                 $time, e.out_red, e.out_green, e.out_blue, e.was_smoothed,
                                 out_item.out_red, out_item.out_green, out_item.out_blue,
                                 out_item.was_smoothed);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_pixel(in_item);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: width_reg = cfg_data[10:0];
                    CFG_ROI_START_X: x0_reg = cfg_data[10:0];
                    CFG_ROI_START_Y: y0_reg = cfg_data;
                    CFG_ROI_END_X:   x1_reg = cfg_data[10:0];
                    CFG_ROI_END_Y:   y1_reg = cfg_data;
                    default: ;
                endcase
            end
            pending = blurred_q.size();
        end
    end

endmodule

>>> tb/tb_roi_gaussian_blur_rgb.sv
// ----------------------------------------------------------------------------
// tb_roi_gaussian_blur_rgb
// Drives frames of RGB pixels under several rectangle and width settings,
// with random idle on both sides and one long result hold-off. The checker
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_roi_gaussian_blur_rgb;
    import rgb_blur_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 40;   // extra wait after the checker queue empties
    localparam int HOLD_AT     = 1200; // items sent before the long hold-off
    localparam int HOLD_LEN    = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    int errors;
    int pending;
    int cycles;
    int sent;
    int hold_cnt;
    bit hold_done;

    roi_gaussian_blur_rgb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    roi_gaussian_blur_rgb_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall, a calm window with none, and one long
    // hold-off so the line pipeline backs up into the pixel input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (!hold_done && sent >= HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (cycles >= 3000 && cycles < 5000)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 37);
    end

    function automatic in_item_t mk(bit drain, bit sof, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b);
        in_item_t it;
        it.func = drain;
        it.start_of_frame = sof;
        it.in_red = r;
        it.in_green = g;
        it.in_blue = b;
        return it;
    endfunction

    // one pixel transaction; payload held while stalled
    task automatic push_item(in_item_t it);
        while (!(sent >= 400 && sent < 700) && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic push_random_pixel(bit sof);
        push_item(mk(1'b0, sof, 8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic push_drains(int n);
        for (int k = 0; k < n; k++)
            push_item(mk(1'b1, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    // let everything drain out before touching registers
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_rect(int w, int x0, int y0, int x1, int y1);
        wait_quiet();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_ROI_START_X, x0);
        cfg_write(CFG_ROI_START_Y, y0);
        cfg_write(CFG_ROI_END_X, x1);
        cfg_write(CFG_ROI_END_Y, y1);
    endtask

    // Well-formed frame with random content; noisy frames sprinkle stray
    // drains and early restarts. Drains at the end flush the window.
    task automatic stream_frame(int w, int rows, bit sof_first, bit noisy);
        int pw;
        pw = (w < 1) ? 1 : w;
        for (int p = 0; p < pw * rows; p++)
        begin
            if (noisy && $urandom_range(0, 99) < 3)
                push_drains(1);
            push_random_pixel((p == 0 && sof_first) ||
                              (noisy && $urandom_range(0, 199) == 0));
        end
        push_drains(pw + 1 + $urandom_range(0, 2));
    endtask

    initial
    begin
        int w, x0, x1, y0, y1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 4 wide, rectangle clipped on both sides of x and at top.
        set_rect(4, 1, 0, 3, 2);
        push_item(mk(1'b1, 1'b1, 8'hFF, 8'h00, 8'hFF));     // drain with sof ignored
        push_item(mk(1'b0, 1'b1, 8'h00, 8'h00, 8'h00));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'h00, 8'h80));
        push_item(mk(1'b0, 1'b0, 8'h7F, 8'h80, 8'h01));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_item(mk(1'b1, 1'b0, 8'h00, 8'h00, 8'h00));     // hole inside the frame
        push_item(mk(1'b0, 1'b0, 8'h55, 8'hAA, 8'hFF));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_item(mk(1'b0, 1'b0, 8'h00, 8'hFF, 8'h00));
        push_item(mk(1'b0, 1'b1, 8'h12, 8'h34, 8'h56));     // restart with pixels pending
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_item(mk(1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_item(mk(1'b0, 1'b0, 8'hAA, 8'h55, 8'h00));
        push_item(mk(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        push_drains(6);

        // narrowest image, zero width treated as one, rectangle at far rows
        set_rect(1, 0, 0, 1, 4095);
        stream_frame(1, 12, 1'b1, 1'b0);
        set_rect(0, 0, 2, 1024, 7);
        stream_frame(1, 10, 1'b1, 1'b0);

        // widest image: first row plus a few pixels of the next, rectangle
        // clipped at the left edge and the top
        set_rect(1024, 0, 0, 5, 2);
        push_random_pixel(1'b1);
        for (int p = 1; p < 1034; p++)
            push_random_pixel(1'b0);
        push_drains(4);

        // random settings, mostly small images; empty, inverted and
        // beyond-width rectangles all come up
        while (sent < 1550)
        begin
            w = $urandom_range(2, 12);
            x0 = $urandom_range(0, w + 1);
            x1 = ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, w + 2);
            y0 = $urandom_range(0, 4);
            y1 = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 9);
            set_rect(w, x0, y0, x1, y1);
            for (int f = 0; f < 3; f++)
                stream_frame(w, $urandom_range(2, 8), f > 0 || $urandom_range(0, 4) != 0,
                             $urandom_range(0, 3) == 0);
        end

        // leave an inverted rectangle so everything passes through
        set_rect(5, 4, 6, 1, 2);
        stream_frame(5, 3, 1'b1, 1'b0);

        wait_quiet();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> roi_gaussian_blur_rgb.f
+incdir+sv
sv/rgb_blur_pkg.sv
sv/roi_gaussian_blur_rgb.sv
sv/rgb_blur_chk.sv
tb/roi_gaussian_blur_rgb_checker.sv
tb/tb_roi_gaussian_blur_rgb.sv
